### src/assert_macros.svh
// Assertion macros shared by the flash sequencer RTL.
// Bodies compile away when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### src/nfcs_pkg.sv
// Package for the NOR flash command sequencer: payload types, codes,
// constants and the controller/datapath command struct. No dependencies.
package nfcs_pkg;

   localparam int ADDR_WIDTH = 32;
   localparam logic [31:0] ADDR_MASK = 32'hFFFF_FFFF >> (32 - ADDR_WIDTH);

   // request ops
   localparam logic [2:0] OP_PROGRAM = 3'd0;
   localparam logic [2:0] OP_ERASE   = 3'd1;
   localparam logic [2:0] OP_READ    = 3'd2;
   localparam logic [2:0] OP_TICK    = 3'd3;
   localparam logic [2:0] OP_QUERY   = 3'd4;
   localparam logic [2:0] OP_RESET   = 3'd5;

   // result kinds
   localparam logic [2:0] K_WRITE = 3'd0;
   localparam logic [2:0] K_READ  = 3'd1;
   localparam logic [2:0] K_OK    = 3'd2;
   localparam logic [2:0] K_FAIL  = 3'd3;
   localparam logic [2:0] K_BUSY  = 3'd4;

   // register indexes
   localparam logic [2:0] R_UNLOCK_SHIFT = 3'd0;
   localparam logic [2:0] R_SECTOR_UNITS = 3'd1;
   localparam logic [2:0] R_POLL_LIMIT   = 3'd2;
   localparam logic [2:0] R_ERASE_WAIT   = 3'd3;
   localparam logic [2:0] R_REMAP_BASE   = 3'd4;
   localparam logic [2:0] R_REMAP_LIMIT  = 3'd5;

   // result slot selectors for the datapath
   localparam logic [2:0] SEL_CMD_5555 = 3'd0;
   localparam logic [2:0] SEL_CMD_2AAA = 3'd1;
   localparam logic [2:0] SEL_DATA     = 3'd2;
   localparam logic [2:0] SEL_SECTOR   = 3'd3;
   localparam logic [2:0] SEL_NONE     = 3'd4;

   localparam logic [15:0] CMD_LO  = 16'h5555;
   localparam logic [15:0] CMD_HI  = 16'h2AAA;
   localparam logic [15:0] D_AA    = 16'h00AA;
   localparam logic [15:0] D_55    = 16'h0055;
   localparam logic [15:0] D_A0    = 16'h00A0;
   localparam logic [15:0] D_80    = 16'h0080;
   localparam logic [15:0] D_ERASE = 16'h0030;
   localparam logic [15:0] D_QUERY = 16'h0098;
   localparam logic [15:0] D_RESET = 16'h00F0;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] target_address;
      logic [23:0] erase_length;
      logic [15:0] write_word;
      logic [15:0] read_word;
   } req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] bus_address;
      logic [15:0] bus_data;
      logic [15:0] sector_number;
      logic        last;
   } rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic        hold_load;   // capture program address/word
      logic        div_start;   // start sector range division
      logic        sec_inc;     // advance current sector
      logic        wait_load;   // load erase wait counter
      logic        wait_dec;    // decrement wait counter
      logic        emit;        // produce one result this cycle
      logic [2:0]  kind;
      logic [2:0]  addr_sel;
      logic [15:0] data;
      logic        data_from_word;
      logic        with_sector;
      logic        last;
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      logic div_busy;
      logic start_bad;   // start sector above 65535
      logic range_end;   // current_sector + 1 >= end_sector
      logic wait_more;   // wait_count > 1
   } sts_type;

endpackage

### src/nor_flash_command_sequencer.sv
// Top level of the NOR flash command sequencer: output register stage
// around nfcs_controller and nfcs_datapath. Uses nfcs_pkg.
//
// Each request is taken in a single handshake; its results then leave one per
// cycle while rsp_stall is low (a program gives five, an erase sector six,
// query/reset three), and no new request is taken until the last one has left
// the output register. An erase request first runs two 40-step serial divisions
// for the sector range before its first write. Stray reads and ticks, and ticks
// that only count down the erase wait, give no result.
module nor_flash_command_sequencer (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  nfcs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output nfcs_pkg::rsp_type rsp_data
);
   nfcs_pkg::ctl_type ctl;
   nfcs_pkg::sts_type sts;
   nfcs_pkg::rsp_type form;
   logic              res_valid, res_taken, ctl_stall;
   logic              out_valid_ff, out_valid_in;
   nfcs_pkg::rsp_type out_data_ff;

   // output register: load when empty or being drained
   assign res_taken    = res_valid && (!out_valid_ff || !rsp_stall);
   assign out_valid_in = res_taken || (out_valid_ff && rsp_stall);
   assign req_stall    = ctl_stall || out_valid_ff;

   nfcs_controller u_ctl (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req_valid (req_valid && !out_valid_ff),
      .req_stall (ctl_stall),
      .req       (req_data),
      .sts       (sts),
      .ctl       (ctl),
      .res_valid (res_valid),
      .res_taken (res_taken)
   );

   nfcs_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .req       (req_data),
      .ctl       (ctl),
      .sts       (sts),
      .rsp_data  (form)
   );

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
      if (res_taken) out_data_ff <= form;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;
endmodule

### src/nfcs_divider.sv
// Restoring serial divider, one quotient bit per cycle (40-bit dividend).
// Depends on nfcs_pkg only through callers; standalone logic.
module nfcs_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [39:0] dividend,
   input  logic [23:0] divisor,
   output logic        busy,
   output logic [39:0] quotient
);
   logic [39:0] quo_ff, quo_in;
   logic [24:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [24:0] trial;

   // one shift-subtract step per cycle
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff[23:0], quo_ff[39]};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         cnt_in  = 6'd40;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            rem_in = trial - {1'b0, divisor};
            quo_in = {quo_ff[38:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[38:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

### src/nfcs_datapath.sv
// Datapath: config registers, held operands, sector range, wait counter,
// result formation. Uses nfcs_pkg and nfcs_divider.
`include "assert_macros.svh"
module nfcs_datapath (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  nfcs_pkg::req_type req,
   input  nfcs_pkg::ctl_type ctl,
   output nfcs_pkg::sts_type sts,
   output nfcs_pkg::rsp_type rsp_data
);
   logic [2:0]  unlock_shift_ff;
   logic [15:0] sector_units_ff;
   logic [23:0] erase_wait_ff;
   logic [31:0] remap_base_ff, remap_limit_ff;
   logic [31:0] held_address_ff;
   logic [15:0] held_word_ff;
   logic [15:0] cur_sec_ff, cur_sec_in;
   logic [16:0] end_sec_ff, end_sec_in;
   logic [23:0] wait_ff, wait_in;
   logic        phase_ff, phase_in;   // 0: start quotient pending, 1: count
   logic [15:0] units;
   logic [23:0] size;
   logic [39:0] div_dividend;
   logic        div_start, div_busy;
   logic [39:0] quotient;
   logic        div_busy_q;
   logic [31:0] start_q_ff;
   logic        start_bad_ff;
   logic [40:0] e_sum;
   logic [31:0] sec_prod;
   logic [31:0] sec_addr;
   logic [31:0] data_addr;
   logic [31:0] addr_pre;
   logic [18:0] cmd_lo, cmd_hi;

   assign units = (sector_units_ff == 16'd0) ? 16'd1 : sector_units_ff;
   assign size  = {units, 8'd0};

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         unlock_shift_ff <= 3'd2;
         sector_units_ff <= 16'd256;
         erase_wait_ff   <= 24'd1000000;
         remap_base_ff   <= 32'h0040_0000;
         remap_limit_ff  <= 32'h0000_2000;
      end else if (csr_write) begin
         unique case (csr_index)
            nfcs_pkg::R_UNLOCK_SHIFT: unlock_shift_ff <= csr_data[2:0];
            nfcs_pkg::R_SECTOR_UNITS: sector_units_ff <= csr_data[15:0];
            nfcs_pkg::R_ERASE_WAIT:   erase_wait_ff   <= csr_data[23:0];
            nfcs_pkg::R_REMAP_BASE:   remap_base_ff   <= csr_data;
            nfcs_pkg::R_REMAP_LIMIT:  remap_limit_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // two divisions: start = addr/size, then count = (len+size-1)/size
   assign div_start = ctl.div_start || (phase_ff == 1'b0 && div_busy_q && !div_busy);
   assign div_dividend = ctl.div_start ? {8'd0, req.target_address}
                       : {15'd0, {1'b0, held_address_ff[23:0]} + {1'b0, size} - 25'd1};

   nfcs_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (size),
      .busy     (div_busy),
      .quotient (quotient)
   );

   assign e_sum = {9'd0, start_q_ff} + {1'b0, quotient} +
                  ((quotient == 40'd0) ? 41'd1 : 41'd0);

   always_comb begin
      cur_sec_in = cur_sec_ff;
      end_sec_in = end_sec_ff;
      phase_in   = phase_ff;
      if (ctl.div_start) phase_in = 1'b0;
      else if (div_busy_q && !div_busy) begin
         if (phase_ff == 1'b0) begin
            phase_in = 1'b1;
            cur_sec_in = quotient[15:0];
         end else begin
            end_sec_in = (e_sum > 41'h10000) ? 17'h10000 : e_sum[16:0];
         end
      end
      if (ctl.sec_inc) cur_sec_in = cur_sec_ff + 16'd1;
   end

   // wait counter
   always_comb begin
      wait_in = wait_ff;
      if (ctl.wait_load) wait_in = erase_wait_ff;
      else if (ctl.wait_dec) wait_in = wait_ff - 24'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_q   <= 1'b0;
         phase_ff     <= 1'b0;
         cur_sec_ff   <= '0;
         end_sec_ff   <= '0;
         wait_ff      <= '0;
         held_address_ff <= '0;
         held_word_ff <= '0;
      end else begin
         div_busy_q <= div_busy;
         phase_ff   <= phase_in;
         cur_sec_ff <= cur_sec_in;
         end_sec_ff <= end_sec_in;
         wait_ff    <= wait_in;
         // erase length parked in held_address low bits while dividing
         if (ctl.hold_load) begin
            held_address_ff <= req.target_address;
            held_word_ff    <= req.write_word;
         end else if (ctl.div_start) begin
            held_address_ff <= {8'd0, req.erase_length};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_busy_q && !div_busy && phase_ff == 1'b0) begin
         start_q_ff   <= quotient[31:0];
         start_bad_ff <= (quotient[39:16] != 24'd0);
      end
   end

   assign sts.div_busy  = div_busy || div_busy_q || div_start || phase_ff == 1'b0;
   assign sts.start_bad = start_bad_ff;
   assign sts.range_end = ({1'b0, cur_sec_ff} + 17'd1) >= end_sec_ff;
   assign sts.wait_more = wait_ff > 24'd1;

   // address forming (sector address: units*256*sector, low 32 bits)
   assign sec_prod = {16'd0, cur_sec_ff} * {16'd0, units};
   assign sec_addr = {sec_prod[23:0], 8'd0};
   assign addr_pre = (ctl.addr_sel == nfcs_pkg::SEL_SECTOR) ? sec_addr : held_address_ff;
   assign data_addr = (addr_pre < remap_limit_ff) ? addr_pre + remap_base_ff : addr_pre;
   assign cmd_lo = {3'd0, nfcs_pkg::CMD_LO} * {16'd0, unlock_shift_ff};
   assign cmd_hi = {3'd0, nfcs_pkg::CMD_HI} * {16'd0, unlock_shift_ff};

   always_comb begin
      rsp_data.kind = ctl.kind;
      rsp_data.last = ctl.last;
      rsp_data.bus_data = ctl.data_from_word ? held_word_ff : ctl.data;
      rsp_data.sector_number = ctl.with_sector ? cur_sec_ff : 16'd0;
      unique case (ctl.addr_sel)
         nfcs_pkg::SEL_CMD_5555: rsp_data.bus_address = {13'd0, cmd_lo};
         nfcs_pkg::SEL_CMD_2AAA: rsp_data.bus_address = {13'd0, cmd_hi};
         nfcs_pkg::SEL_DATA,
         nfcs_pkg::SEL_SECTOR:   rsp_data.bus_address = data_addr;
         default:                rsp_data.bus_address = 32'd0;
      endcase
      rsp_data.bus_address = rsp_data.bus_address & nfcs_pkg::ADDR_MASK;
   end

   `ASSERT_NEXT(a_sec_inc, clock, reset, ctl.sec_inc, cur_sec_ff == $past(cur_sec_ff) + 16'd1)
   `ASSERT_NEXT(a_wait_load, clock, reset, ctl.wait_load, wait_ff == $past(erase_wait_ff))
   `ASSERT_IMPL(a_no_both, clock, reset, ctl.wait_load, !ctl.wait_dec)
endmodule

### src/nfcs_controller.sv
// Controller FSM: sequences writes, polls and erase steps, one result per
// step. Uses nfcs_pkg and drives the datapath through ctl_type.
`include "assert_macros.svh"
module nfcs_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data,
   input  logic              req_valid,
   output logic              req_stall,
   input  nfcs_pkg::req_type req,
   input  nfcs_pkg::sts_type sts,
   output nfcs_pkg::ctl_type ctl,
   output logic              res_valid,
   input  logic              res_taken
);
   // states
   localparam logic [3:0] S_IDLE  = 4'd0;  // mode idle, accepting
   localparam logic [3:0] S_POLL  = 4'd1;  // mode poll, accepting
   localparam logic [3:0] S_ERW   = 4'd2;  // mode erase wait, accepting
   localparam logic [3:0] S_PROG  = 4'd3;  // emitting program attempt
   localparam logic [3:0] S_ERSEQ = 4'd4;  // emitting erase sequence
   localparam logic [3:0] S_CMD3  = 4'd5;  // emitting query/reset
   localparam logic [3:0] S_DIV   = 4'd6;  // waiting on sector division
   localparam logic [3:0] S_ONE   = 4'd7;  // emitting one result

   logic [3:0]  state_ff, state_in;
   logic [3:0]  ret_ff, ret_in;     // accepting state after S_ONE
   logic [2:0]  step_ff, step_in;
   logic        retry_ff, retry_in;
   logic [9:0]  pcount_ff, pcount_in;
   logic        first_ff, first_in;
   logic        prev_ff, prev_in;
   logic        query_ff, query_in;
   logic [9:0]  plimit_ff;
   logic [2:0]  one_kind_ff, one_kind_in;
   logic [2:0]  one_sel_ff, one_sel_in;
   logic        one_sec_ff, one_sec_in;
   logic        accept, accepting, cmd_op, bit6;
   logic [9:0]  pc_next;

   assign accepting = (state_ff == S_IDLE) || (state_ff == S_POLL) || (state_ff == S_ERW);
   assign req_stall = !accepting;
   assign accept    = req_valid && accepting;
   assign cmd_op    = (req.op == nfcs_pkg::OP_PROGRAM) || (req.op == nfcs_pkg::OP_ERASE) ||
                      (req.op == nfcs_pkg::OP_QUERY) || (req.op == nfcs_pkg::OP_RESET);
   assign bit6      = req.read_word[6];

   always_ff @(posedge clock) begin
      if (reset) plimit_ff <= 10'd500;
      else if (csr_write && csr_index == nfcs_pkg::R_POLL_LIMIT) plimit_ff <= csr_data[9:0];
   end

   always_comb begin
      state_in = state_ff; ret_in = ret_ff; step_in = step_ff;
      retry_in = retry_ff; pcount_in = pcount_ff; first_in = first_ff;
      prev_in = prev_ff; query_in = query_ff;
      one_kind_in = one_kind_ff; one_sel_in = one_sel_ff; one_sec_in = one_sec_ff;
      pc_next = pcount_ff;
      ctl = '0;
      ctl.addr_sel = nfcs_pkg::SEL_NONE;
      res_valid = 1'b0;
      unique case (state_ff)
         S_IDLE, S_POLL, S_ERW: begin
            if (accept) begin
               if (cmd_op && state_ff != S_IDLE) begin
                  state_in = S_ONE; ret_in = state_ff;
                  one_kind_in = nfcs_pkg::K_BUSY; one_sel_in = nfcs_pkg::SEL_NONE;
                  one_sec_in = 1'b0;
               end else if (req.op == nfcs_pkg::OP_PROGRAM) begin
                  ctl.hold_load = 1'b1; retry_in = 1'b0;
                  state_in = S_PROG; step_in = '0;
               end else if (req.op == nfcs_pkg::OP_ERASE) begin
                  ctl.div_start = 1'b1; state_in = S_DIV;
               end else if (req.op == nfcs_pkg::OP_QUERY || req.op == nfcs_pkg::OP_RESET) begin
                  query_in = (req.op == nfcs_pkg::OP_QUERY);
                  state_in = S_CMD3; step_in = '0;
               end else if (req.op == nfcs_pkg::OP_READ && state_ff == S_POLL) begin
                  if (!first_ff && bit6 == prev_ff) begin
                     state_in = S_ONE; ret_in = S_IDLE;
                     one_kind_in = nfcs_pkg::K_OK; one_sel_in = nfcs_pkg::SEL_NONE;
                     one_sec_in = 1'b0;
                  end else begin
                     if (!first_ff) pc_next = pcount_ff + 10'd1;
                     first_in = 1'b0; prev_in = bit6; pcount_in = pc_next;
                     if (pc_next >= plimit_ff) begin
                        if (!retry_ff) begin
                           retry_in = 1'b1; state_in = S_PROG; step_in = '0;
                        end else begin
                           state_in = S_ONE; ret_in = S_IDLE;
                           one_kind_in = nfcs_pkg::K_FAIL;
                           one_sel_in = nfcs_pkg::SEL_NONE; one_sec_in = 1'b0;
                        end
                     end else begin
                        state_in = S_ONE; ret_in = S_POLL;
                        one_kind_in = nfcs_pkg::K_READ; one_sel_in = nfcs_pkg::SEL_DATA;
                        one_sec_in = 1'b0;
                     end
                  end
               end else if (req.op == nfcs_pkg::OP_TICK && state_ff == S_ERW) begin
                  if (sts.wait_more) ctl.wait_dec = 1'b1;
                  else begin
                     ctl.wait_load = 1'b0;
                     if (sts.range_end) begin
                        state_in = S_ONE; ret_in = S_IDLE;
                        one_kind_in = nfcs_pkg::K_OK; one_sel_in = nfcs_pkg::SEL_NONE;
                        one_sec_in = 1'b1;
                     end else begin
                        ctl.sec_inc = 1'b1; state_in = S_ERSEQ; step_in = '0;
                     end
                  end
               end
            end
         end
         S_DIV: begin
            if (!sts.div_busy) begin
               if (sts.start_bad) begin
                  state_in = S_ONE; ret_in = S_IDLE;
                  one_kind_in = nfcs_pkg::K_FAIL; one_sel_in = nfcs_pkg::SEL_NONE;
                  one_sec_in = 1'b0;
               end else begin
                  state_in = S_ERSEQ; step_in = '0;
               end
            end
         end
         S_ONE: begin
            res_valid = 1'b1;
            ctl.emit = 1'b1; ctl.kind = one_kind_ff; ctl.addr_sel = one_sel_ff;
            ctl.with_sector = one_sec_ff; ctl.last = 1'b1;
            if (res_taken) state_in = ret_ff;
         end
         S_PROG: begin
            res_valid = 1'b1; ctl.emit = 1'b1;
            unique case (step_ff)
               3'd0: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.data = nfcs_pkg::D_AA; end
               3'd1: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_2AAA; ctl.data = nfcs_pkg::D_55; end
               3'd2: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.data = nfcs_pkg::D_A0; end
               3'd3: begin ctl.addr_sel = nfcs_pkg::SEL_DATA; ctl.data_from_word = 1'b1; end
               default: begin
                  ctl.addr_sel = nfcs_pkg::SEL_DATA; ctl.kind = nfcs_pkg::K_READ;
                  ctl.last = 1'b1;
               end
            endcase
            if (step_ff != 3'd4) ctl.kind = nfcs_pkg::K_WRITE;
            if (res_taken) begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd4) begin
                  state_in = S_POLL; pcount_in = '0; first_in = 1'b1; prev_in = 1'b0;
               end
            end
         end
         S_ERSEQ: begin
            res_valid = 1'b1; ctl.emit = 1'b1; ctl.kind = nfcs_pkg::K_WRITE;
            ctl.with_sector = 1'b1;
            unique case (step_ff)
               3'd0, 3'd3: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.data = nfcs_pkg::D_AA; end
               3'd1, 3'd4: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_2AAA; ctl.data = nfcs_pkg::D_55; end
               3'd2: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.data = nfcs_pkg::D_80; end
               default: begin
                  ctl.addr_sel = nfcs_pkg::SEL_SECTOR; ctl.data = nfcs_pkg::D_ERASE;
                  ctl.last = 1'b1;
               end
            endcase
            if (res_taken) begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd5) begin
                  state_in = S_ERW; ctl.wait_load = 1'b1;
               end
            end
         end
         S_CMD3: begin
            res_valid = 1'b1; ctl.emit = 1'b1; ctl.kind = nfcs_pkg::K_WRITE;
            unique case (step_ff)
               3'd0: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.data = nfcs_pkg::D_AA; end
               3'd1: begin ctl.addr_sel = nfcs_pkg::SEL_CMD_2AAA; ctl.data = nfcs_pkg::D_55; end
               default: begin
                  ctl.addr_sel = nfcs_pkg::SEL_CMD_5555; ctl.last = 1'b1;
                  ctl.data = query_ff ? nfcs_pkg::D_QUERY : nfcs_pkg::D_RESET;
               end
            endcase
            if (res_taken) begin
               step_in = step_ff + 3'd1;
               if (step_ff == 3'd2) state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; ret_ff <= S_IDLE; step_ff <= '0;
         retry_ff <= 1'b0; pcount_ff <= '0; first_ff <= 1'b1; prev_ff <= 1'b0;
         query_ff <= 1'b0;
      end else begin
         state_ff <= state_in; ret_ff <= ret_in; step_ff <= step_in;
         retry_ff <= retry_in; pcount_ff <= pcount_in; first_ff <= first_in;
         prev_ff <= prev_in; query_ff <= query_in;
      end
      one_kind_ff <= one_kind_in; one_sel_ff <= one_sel_in; one_sec_ff <= one_sec_in;
   end

   `ASSERT_IMPL(a_emit_not_accepting, clock, reset, res_valid, req_stall)
   `ASSERT_IMPL(a_step_range, clock, reset, state_ff == S_PROG, step_ff <= 3'd4)
   `ASSERT_NEXT(a_div_leaves, clock, reset, ctl.div_start, state_ff == S_DIV)
endmodule

### sim/testbench.sv
// Testbench for nor_flash_command_sequencer: predicts every bus access and
// completion from a behavioral copy of the sequencer. Uses nfcs_pkg.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_write = 0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;
   logic        req_valid = 0;
   logic        req_stall;
   nfcs_pkg::req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   nfcs_pkg::rsp_type rsp_data;

   nor_flash_command_sequencer u_dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // predictor state
   localparam logic [1:0] M_IDLE = 2'd0, M_POLL = 2'd1, M_ERASE = 2'd2;
   logic [2:0]  p_shift = 3'd2;
   logic [15:0] p_units = 16'd256;
   logic [9:0]  p_plimit = 10'd500;
   logic [23:0] p_ewait = 24'd1000000;
   logic [31:0] p_rbase = 32'h400000, p_rlimit = 32'h2000;
   logic [1:0]  seq_mode = M_IDLE;
   logic        retry_used = 0, first_poll = 1, prev_toggle = 0;
   logic [9:0]  poll_count = 0;
   logic [31:0] held_addr = 0;
   logic [15:0] held_word = 0;
   logic [15:0] cur_sector = 0;
   logic [16:0] end_sector = 0;
   logic [23:0] wait_count = 0;

   nfcs_pkg::rsp_type expected_rsps[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0, recv_idle_pct = 0;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      error_count++;
   endtask

   function automatic logic [31:0] cmd_addr(input logic [15:0] base);
      return (32'(base) * 32'(p_shift)) & nfcs_pkg::ADDR_MASK;
   endfunction

   function automatic logic [31:0] remap_addr(input logic [31:0] a);
      return (a < p_rlimit) ? a + p_rbase : a;
   endfunction

   function automatic logic [31:0] sec_bytes();
      return (p_units == 0 ? 32'd1 : 32'(p_units)) * 256;
   endfunction

   function automatic void push_rsp(input logic [2:0] k, input logic [31:0] a,
                                    input logic [15:0] d, input logic [15:0] s,
                                    input logic l);
      nfcs_pkg::rsp_type r;
      r.kind = k; r.bus_address = a & nfcs_pkg::ADDR_MASK; r.bus_data = d;
      r.sector_number = s; r.last = l;
      expected_rsps.push_back(r);
   endfunction

   function automatic void issue_program();
      logic [31:0] a;
      a = remap_addr(held_addr);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_AA, 0, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_HI), nfcs_pkg::D_55, 0, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_A0, 0, 0);
      push_rsp(nfcs_pkg::K_WRITE, a, held_word, 0, 0);
      push_rsp(nfcs_pkg::K_READ, a, 0, 0, 1);
      seq_mode = M_POLL; poll_count = 0; first_poll = 1; prev_toggle = 0;
   endfunction

   function automatic void issue_sector();
      logic [31:0] a;
      logic [63:0] prod;
      prod = 64'(cur_sector) * 64'(sec_bytes());
      a = remap_addr(prod[31:0]);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_AA, cur_sector, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_HI), nfcs_pkg::D_55, cur_sector, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_80, cur_sector, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_AA, cur_sector, 0);
      push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_HI), nfcs_pkg::D_55, cur_sector, 0);
      push_rsp(nfcs_pkg::K_WRITE, a, nfcs_pkg::D_ERASE, cur_sector, 1);
      wait_count = p_ewait; seq_mode = M_ERASE;
   endfunction

   // works out the results one accepted request causes
   function automatic void predict_request(input nfcs_pkg::req_type q);
      logic [63:0] sz, s, e;
      if ((q.op == nfcs_pkg::OP_PROGRAM || q.op == nfcs_pkg::OP_ERASE ||
           q.op == nfcs_pkg::OP_QUERY || q.op == nfcs_pkg::OP_RESET) &&
          seq_mode != M_IDLE) begin
         push_rsp(nfcs_pkg::K_BUSY, 0, 0, 0, 1);
         return;
      end
      case (q.op)
         nfcs_pkg::OP_PROGRAM: begin
            held_addr = q.target_address; held_word = q.write_word;
            retry_used = 0; issue_program();
         end
         nfcs_pkg::OP_ERASE: begin
            sz = 64'(sec_bytes());
            s = 64'(q.target_address) / sz;
            if (s > 64'hFFFF) push_rsp(nfcs_pkg::K_FAIL, 0, 0, 0, 1);
            else begin
               e = s + (64'(q.erase_length) + sz - 1) / sz;
               if (e == s) e++;
               if (e > 64'h10000) e = 64'h10000;
               cur_sector = s[15:0]; end_sector = e[16:0];
               issue_sector();
            end
         end
         nfcs_pkg::OP_READ: begin
            if (seq_mode == M_POLL) begin
               if (!first_poll && q.read_word[6] == prev_toggle) begin
                  seq_mode = M_IDLE; push_rsp(nfcs_pkg::K_OK, 0, 0, 0, 1); return;
               end
               if (first_poll) first_poll = 0; else poll_count++;
               prev_toggle = q.read_word[6];
               if (poll_count >= p_plimit) begin
                  if (!retry_used) begin
                     retry_used = 1; issue_program();
                  end else begin
                     seq_mode = M_IDLE; push_rsp(nfcs_pkg::K_FAIL, 0, 0, 0, 1);
                  end
               end else push_rsp(nfcs_pkg::K_READ, remap_addr(held_addr), 0, 0, 1);
            end
         end
         nfcs_pkg::OP_TICK: begin
            if (seq_mode == M_ERASE) begin
               if (wait_count > 1) wait_count--;
               else begin
                  wait_count = 0;
                  if (17'(cur_sector) + 1 >= end_sector) begin
                     seq_mode = M_IDLE; push_rsp(nfcs_pkg::K_OK, 0, 0, cur_sector, 1);
                  end else begin
                     cur_sector++; issue_sector();
                  end
               end
            end
         end
         nfcs_pkg::OP_QUERY, nfcs_pkg::OP_RESET: begin
            push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO), nfcs_pkg::D_AA, 0, 0);
            push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_HI), nfcs_pkg::D_55, 0, 0);
            push_rsp(nfcs_pkg::K_WRITE, cmd_addr(nfcs_pkg::CMD_LO),
                     q.op == nfcs_pkg::OP_QUERY ? nfcs_pkg::D_QUERY : nfcs_pkg::D_RESET,
                     0, 1);
         end
         default: ;
      endcase
   endfunction

   // result checker and receiver stall
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0)
               report_mismatch($sformatf("unexpected result %p", rsp_data));
            else begin
               nfcs_pkg::rsp_type x;
               x = expected_rsps.pop_front();
               if (rsp_data.kind != x.kind)
                  report_mismatch($sformatf("kind %0d want %0d", rsp_data.kind, x.kind));
               if (rsp_data.bus_address != x.bus_address)
                  report_mismatch($sformatf("address %h want %h",
                                            rsp_data.bus_address, x.bus_address));
               if (rsp_data.bus_data != x.bus_data)
                  report_mismatch($sformatf("data %h want %h", rsp_data.bus_data, x.bus_data));
               if (rsp_data.sector_number != x.sector_number)
                  report_mismatch($sformatf("sector %0d want %0d",
                                            rsp_data.sector_number, x.sector_number));
               if (rsp_data.last != x.last)
                  report_mismatch($sformatf("last %0d want %0d", rsp_data.last, x.last));
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
      if (cycle_count > 3000000) begin
         $display("FAIL");
         $finish;
      end
   end

   // one request transfer; idle gaps before it at the sender's rate.
   // valid stays up after the transfer so the next one can follow directly;
   // anything that waits without sending drops it first.
   task automatic send_request(input nfcs_pkg::req_type q);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1; req_data <= q;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_request(q);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] v);
      req_valid <= 0;
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
      case (idx)
         nfcs_pkg::R_UNLOCK_SHIFT: p_shift = v[2:0];
         nfcs_pkg::R_SECTOR_UNITS: p_units = v[15:0];
         nfcs_pkg::R_POLL_LIMIT:   p_plimit = v[9:0];
         nfcs_pkg::R_ERASE_WAIT:   p_ewait = v[23:0];
         nfcs_pkg::R_REMAP_BASE:   p_rbase = v;
         nfcs_pkg::R_REMAP_LIMIT:  p_rlimit = v;
         default: ;
      endcase
   endtask

   function automatic nfcs_pkg::req_type mk(input logic [2:0] op, input logic [31:0] a = 0,
                                            input logic [23:0] l = 0,
                                            input logic [15:0] w = 0,
                                            input logic [15:0] r = 0);
      nfcs_pkg::req_type q;
      q.op = op; q.target_address = a; q.erase_length = l;
      q.write_word = w; q.read_word = r;
      return q;
   endfunction

   // flush any ongoing run so the block returns to idle
   task automatic settle_idle();
      while (seq_mode == M_POLL) send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0, 16'h0040));
      while (seq_mode == M_ERASE) send_request(mk(nfcs_pkg::OP_TICK));
   endtask

   task automatic test_directed();
      write_reg(nfcs_pkg::R_ERASE_WAIT, 2);
      write_reg(nfcs_pkg::R_POLL_LIMIT, 2);
      send_request(mk(nfcs_pkg::OP_QUERY));
      send_request(mk(nfcs_pkg::OP_RESET));
      send_request(mk(nfcs_pkg::OP_READ));               // stray read
      send_request(mk(nfcs_pkg::OP_TICK));               // stray tick
      send_request(mk(3'd6, '1, '1, '1, '1));            // unused op
      send_request(mk(3'd7));
      send_request(mk(nfcs_pkg::OP_PROGRAM, 32'h100, 0, 16'hFFFF));
      send_request(mk(nfcs_pkg::OP_QUERY));              // busy
      send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0, 16'h0000));
      send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0, 16'h0000)); // agree: done
      send_request(mk(nfcs_pkg::OP_PROGRAM, 32'hFFFF_FFFF, 0, 16'h0000));
      repeat (6) send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0,
                                 16'hFFBF ^ {9'd0, cycle_count[0], 6'd0}));
      settle_idle();
      // toggling forever: timeout, retry, then fail
      send_request(mk(nfcs_pkg::OP_PROGRAM, 32'h1FFF, 0, 16'h1234));
      for (int i = 0; i < 8 && seq_mode == M_POLL; i++)
         send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0, (i % 2) ? 16'h0040 : 16'h0000));
      settle_idle();
      send_request(mk(nfcs_pkg::OP_ERASE, 32'h1_0000, 24'h0, 0));       // zero length
      send_request(mk(nfcs_pkg::OP_PROGRAM));                            // busy
      settle_idle();
      send_request(mk(nfcs_pkg::OP_ERASE, 32'hFFFF_FFFF, 24'hFF_FFFF)); // top sector
      settle_idle();
      send_request(mk(nfcs_pkg::OP_ERASE, 32'hFFFF_0000, 24'h02_0000)); // end saturates
      settle_idle();
      wait_drained();
      write_reg(nfcs_pkg::R_POLL_LIMIT, 0);              // first read retries, next read fails
      send_request(mk(nfcs_pkg::OP_PROGRAM, 32'h2000, 0, 16'h5A5A));
      send_request(mk(nfcs_pkg::OP_READ, 0, 0, 0, 16'h0040));
      settle_idle();
      wait_drained();
   endtask

   // random traffic, mostly well-formed request runs
   task automatic test_random(input int n_items);
      int sent;
      logic [2:0] op;
      sent = 0;
      while (sent < n_items) begin
         case ($urandom_range(9))
            0, 1, 2: op = nfcs_pkg::OP_PROGRAM;
            3, 4:    op = nfcs_pkg::OP_ERASE;
            5:       op = nfcs_pkg::OP_QUERY;
            6:       op = nfcs_pkg::OP_RESET;
            default: op = 3'($urandom_range(7));
         endcase
         if (seq_mode == M_IDLE || $urandom_range(9) == 0) begin
            send_request(mk(op, ($urandom_range(3) == 0) ? $urandom : $urandom_range(32'h8000),
                            24'($urandom_range(2048)),
                            16'($urandom), 16'($urandom)));
            sent++;
         end else if (seq_mode == M_POLL) begin
            send_request(mk(nfcs_pkg::OP_READ, $urandom, 24'($urandom), 16'($urandom),
                            16'($urandom)));
            sent++;
         end else begin
            if (end_sector - 17'(cur_sector) > 4 && $urandom_range(3) != 0) settle_tail();
            else send_request(mk(nfcs_pkg::OP_TICK, $urandom, 24'($urandom), 16'($urandom),
                                 16'($urandom)));
            sent++;
         end
      end
      settle_idle();
      wait_drained();
   endtask

   // busy request in the middle of an erase run, then a burst of ticks
   task automatic settle_tail();
      send_request(mk(nfcs_pkg::OP_QUERY));
      repeat (3) send_request(mk(nfcs_pkg::OP_TICK));
   endtask

   task automatic test_config_phase(input int n_items, input logic [2:0] sh,
                                    input logic [15:0] su, input logic [9:0] pl,
                                    input logic [23:0] ew, input logic [31:0] rb,
                                    input logic [31:0] rl);
      write_reg(nfcs_pkg::R_UNLOCK_SHIFT, sh);
      write_reg(nfcs_pkg::R_SECTOR_UNITS, su);
      write_reg(nfcs_pkg::R_POLL_LIMIT, pl);
      write_reg(nfcs_pkg::R_ERASE_WAIT, ew);
      write_reg(nfcs_pkg::R_REMAP_BASE, rb);
      write_reg(nfcs_pkg::R_REMAP_LIMIT, rl);
      test_random(n_items);
   endtask

   task automatic test_pause_until_drained();
      send_request(mk(nfcs_pkg::OP_QUERY));
      wait_drained();
      send_request(mk(nfcs_pkg::OP_RESET));
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_idle_pct = 22; recv_idle_pct = 52;
      test_directed();
      test_config_phase(50, 3'd1, 16'd1, 10'd3, 24'd0, 32'h0, 32'h0);
      send_idle_pct = 52; recv_idle_pct = 22;
      test_config_phase(50, 3'd4, 16'd4, 10'd1, 24'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      test_pause_until_drained();
      send_idle_pct = 0; recv_idle_pct = 0;
      test_config_phase(50, 3'd7, 16'hFFFF, 10'h3FF, 24'd1, 32'hA5A5_0000, 32'h8000);
      test_config_phase(30, 3'd0, 16'd0, 10'd2, 24'd2, 32'h1234_5678, 32'h4000);
      wait_drained();
      if (error_count == 0) $display("PASS");
      else $display("FAIL");
      $finish;
   end
endmodule

### sim.f
+incdir+src
src/nfcs_pkg.sv
src/nfcs_divider.sv
src/nfcs_datapath.sv
src/nfcs_controller.sv
src/nor_flash_command_sequencer.sv
sim/testbench.sv
